// File: src/assert_macros.svh
// Assertion macros shared by the arithmetic unit and the controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// File: src/ngf_pkg.sv
// Shared types, constants and codes of the 2D gravity force block.
package ngf_pkg;

  localparam int MAX_PARTICLES_DEF = 64;
  localparam int GRAV_W = 48;
  localparam logic [GRAV_W-1:0] GRAV_RESET = 48'd187860;
  localparam int IDX_W = 6;

  // Operation codes of the iterative arithmetic unit.
  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  // Steps of one pair evaluation, in the order they run.
  localparam logic [3:0] STEP_UXX = 4'd0;
  localparam logic [3:0] STEP_UYY = 4'd1;
  localparam logic [3:0] STEP_SQRT = 4'd2;
  localparam logic [3:0] STEP_MM  = 4'd3;
  localparam logic [3:0] STEP_GM  = 4'd4;
  localparam logic [3:0] STEP_FDIV = 4'd5;
  localparam logic [3:0] STEP_TXM = 4'd6;
  localparam logic [3:0] STEP_TXD = 4'd7;
  localparam logic [3:0] STEP_TYM = 4'd8;
  localparam logic [3:0] STEP_TYD = 4'd9;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        mass;
    logic               last_particle;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   particle_index;
    logic signed [63:0] force_x;
    logic signed [63:0] force_y;
    logic               coincident;
    logic               saturated;
    logic               last_result;
  } out_item_t;

  typedef struct packed {
    logic             mem_we;
    logic             latch_i;
    logic             latch_d;
    logic             set_coin;
    logic             go;
    logic [3:0]       step;
    logic             emit;
    logic             out_last;
    logic [IDX_W-1:0] out_idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic done;
    logic pair_zero;
  } dp_status_t;

  // Arithmetic operation that a pair step uses.
  function automatic logic [1:0] step_op(input logic [3:0] step);
    logic [1:0] op;
    case (step)
      STEP_SQRT: op = OP_SQRT;
      STEP_FDIV, STEP_TXD, STEP_TYD: op = OP_DIV;
      default: op = OP_MUL;
    endcase
    return op;
  endfunction

endpackage

// File: src/ngf_arith.sv
// Iterative multiply, divide and square root unit, one bit or digit per cycle.
`include "assert_macros.svh"

module ngf_arith (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         go_i,
  input  logic [1:0]   op_i,
  input  logic [127:0] a_i,
  input  logic [64:0]  b_i,
  output logic         done_o,
  output logic [127:0] res_o
);

  logic [1:0]   op_q;
  logic         busy_q;
  logic         done_q;
  logic [6:0]   cnt_q;
  logic [127:0] acc_q, acc_d;
  logic [65:0]  rem_q, rem_d;
  logic [64:0]  aux_q, aux_d;
  logic [65:0]  shr;
  logic [65:0]  trial;

  // One iteration of the selected operation.
  always_comb begin
    acc_d = acc_q;
    rem_d = rem_q;
    aux_d = aux_q;
    shr   = '0;
    trial = '0;
    case (op_q)
      ngf_pkg::OP_MUL: begin
        acc_d = {acc_q[126:0], 1'b0} + (rem_q[63] ? {64'b0, aux_q[63:0]} : 128'b0);
        rem_d = {rem_q[64:0], 1'b0};
      end
      ngf_pkg::OP_DIV: begin
        shr = {rem_q[64:0], acc_q[127]};
        if (shr >= {1'b0, aux_q}) begin
          rem_d = shr - {1'b0, aux_q};
          acc_d = {acc_q[126:0], 1'b1};
        end else begin
          rem_d = shr;
          acc_d = {acc_q[126:0], 1'b0};
        end
      end
      ngf_pkg::OP_SQRT: begin
        shr   = {rem_q[63:0], acc_q[127:126]};
        trial = {31'b0, aux_q[32:0], 2'b01};
        acc_d = {acc_q[125:0], 2'b00};
        if (shr >= trial) begin
          rem_d = shr - trial;
          aux_d = {aux_q[63:0], 1'b1};
        end else begin
          rem_d = shr;
          aux_d = {aux_q[63:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // Control of the iteration count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= ngf_pkg::OP_MUL;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        op_q   <= op_i;
        case (op_i)
          ngf_pkg::OP_DIV:  cnt_q <= 7'd127;
          ngf_pkg::OP_SQRT: cnt_q <= 7'd32;
          default:          cnt_q <= 7'd63;
        endcase
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      case (op_i)
        ngf_pkg::OP_DIV: begin
          acc_q <= a_i;
          rem_q <= '0;
          aux_q <= b_i;
        end
        ngf_pkg::OP_SQRT: begin
          acc_q <= {1'b0, b_i, 62'b0};
          rem_q <= '0;
          aux_q <= '0;
        end
        default: begin
          acc_q <= '0;
          rem_q <= {2'b0, b_i[63:0]};
          aux_q <= {1'b0, a_i[63:0]};
        end
      endcase
    end else if (busy_q) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
      aux_q <= aux_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = (op_q == ngf_pkg::OP_SQRT) ? {95'b0, aux_q[32:0]} : acc_q;

  `ASSERT_NXT(a_done_after_last, clk_i, rst_ni, busy_q && !go_i && cnt_q == 7'd0, done_q)
  `ASSERT_IMP(a_done_not_busy, clk_i, rst_ni, done_q, !busy_q)

endmodule

// File: src/ngf_dpath.sv
// Datapath: particle stores, pair arithmetic, force sums and result register.
module ngf_dpath #(
  parameter int MaxParticles = ngf_pkg::MAX_PARTICLES_DEF,
  localparam int AddrW = $clog2(MaxParticles)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ngf_pkg::in_item_t              item_i,
  input  logic                           cfg_we_i,
  input  logic [ngf_pkg::GRAV_W-1:0]     cfg_wdata_i,
  input  ngf_pkg::ctrl_cmd_t             cmd_i,
  input  logic [AddrW-1:0]               rd_addr_i,
  input  logic [AddrW-1:0]               wr_addr_i,
  output ngf_pkg::dp_status_t            status_o,
  output logic                           result_valid_o,
  output ngf_pkg::out_item_t             result_o
);

  logic signed [31:0] x_mem [MaxParticles];
  logic signed [31:0] y_mem [MaxParticles];
  logic [31:0]        m_mem [MaxParticles];

  logic [ngf_pkg::GRAV_W-1:0] grav_q;
  logic signed [31:0] rd_x_q, rd_y_q, xi_q, yi_q;
  logic [31:0]        rd_m_q, mi_q;
  logic [31:0]        ux_q, uy_q;
  logic               xneg_q, yneg_q, xz_q, yz_q;
  logic [64:0]        d2_q;
  logic [32:0]        d_q;
  logic [63:0]        p_q, f_q;
  logic [127:0]       num_q;
  logic [95:0]        t_q;
  logic signed [63:0] fx_q, fy_q;
  logic               coin_q, sat_q;
  logic               valid_q;
  ngf_pkg::out_item_t res_q;

  logic signed [32:0] dx, dy;
  logic               done;
  logic [127:0]       ares;
  logic [127:0]       op_a;
  logic [64:0]        op_b;
  logic               term_clip, term_neg, sum_ovf;
  logic [63:0]        mag;
  logic signed [63:0] term, acc_in, acc_out;
  logic signed [64:0] sum;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q <= ngf_pkg::GRAV_RESET;
    end else if (cfg_we_i) begin
      grav_q <= cfg_wdata_i;
    end
  end

  // Particle stores with registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      x_mem[wr_addr_i] <= item_i.pos_x;
      y_mem[wr_addr_i] <= item_i.pos_y;
      m_mem[wr_addr_i] <= item_i.mass;
    end
    rd_x_q <= x_mem[rd_addr_i];
    rd_y_q <= y_mem[rd_addr_i];
    rd_m_q <= m_mem[rd_addr_i];
  end

  // Offsets from particle i to particle j.
  assign dx = {rd_x_q[31], rd_x_q} - {xi_q[31], xi_q};
  assign dy = {rd_y_q[31], rd_y_q} - {yi_q[31], yi_q};

  // Operand selection for the arithmetic unit.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.step)
      ngf_pkg::STEP_UXX: begin
        op_a = {96'b0, ux_q};
        op_b = {33'b0, ux_q};
      end
      ngf_pkg::STEP_UYY: begin
        op_a = {96'b0, uy_q};
        op_b = {33'b0, uy_q};
      end
      ngf_pkg::STEP_SQRT: op_b = d2_q;
      ngf_pkg::STEP_MM: begin
        op_a = {96'b0, mi_q};
        op_b = {33'b0, rd_m_q};
      end
      ngf_pkg::STEP_GM: begin
        op_a = {80'b0, grav_q};
        op_b = {1'b0, p_q};
      end
      ngf_pkg::STEP_FDIV: begin
        op_a = num_q;
        op_b = d2_q;
      end
      ngf_pkg::STEP_TXM: begin
        op_a = {64'b0, f_q};
        op_b = {33'b0, ux_q};
      end
      ngf_pkg::STEP_TYM: begin
        op_a = {64'b0, f_q};
        op_b = {33'b0, uy_q};
      end
      ngf_pkg::STEP_TXD, ngf_pkg::STEP_TYD: begin
        op_a = {32'b0, t_q};
        op_b = {32'b0, d_q};
      end
      default: ;
    endcase
  end

  ngf_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.go),
    .op_i   (ngf_pkg::step_op(cmd_i.step)),
    .a_i    (op_a),
    .b_i    (op_b),
    .done_o (done),
    .res_o  (ares)
  );

  // Clipped, signed term and saturating add into the running sum.
  always_comb begin
    term_clip = |ares[127:63];
    mag       = term_clip ? {1'b0, {63{1'b1}}} : ares[63:0];
    term_neg  = (cmd_i.step == ngf_pkg::STEP_TXD) ? xneg_q : yneg_q;
    term      = term_neg ? -$signed(mag) : $signed(mag);
    acc_in    = (cmd_i.step == ngf_pkg::STEP_TXD) ? fx_q : fy_q;
    sum       = {acc_in[63], acc_in} + {term[63], term};
    sum_ovf   = sum[64] ^ sum[63];
    if (sum_ovf) begin
      acc_out = sum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end else begin
      acc_out = sum[63:0];
    end
  end

  // Pair registers and force sums.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_i) begin
      xi_q   <= rd_x_q;
      yi_q   <= rd_y_q;
      mi_q   <= rd_m_q;
      fx_q   <= '0;
      fy_q   <= '0;
      coin_q <= 1'b0;
      sat_q  <= 1'b0;
    end
    if (cmd_i.latch_d) begin
      ux_q   <= dx[32] ? 32'(-dx) : dx[31:0];
      uy_q   <= dy[32] ? 32'(-dy) : dy[31:0];
      xneg_q <= dx[32];
      yneg_q <= dy[32];
      xz_q   <= (dx == '0);
      yz_q   <= (dy == '0);
    end
    if (cmd_i.set_coin) begin
      coin_q <= 1'b1;
    end
    if (done) begin
      case (cmd_i.step)
        ngf_pkg::STEP_UXX:  d2_q <= ares[64:0];
        ngf_pkg::STEP_UYY:  d2_q <= d2_q + ares[64:0];
        ngf_pkg::STEP_SQRT: d_q  <= ares[32:0];
        ngf_pkg::STEP_MM:   p_q  <= ares[63:0];
        ngf_pkg::STEP_GM:   num_q <= {ares[111:0], 16'b0};
        ngf_pkg::STEP_FDIV: begin
          f_q <= (|ares[127:64]) ? {64{1'b1}} : ares[63:0];
          if (|ares[127:64]) begin
            sat_q <= 1'b1;
          end
        end
        ngf_pkg::STEP_TXM, ngf_pkg::STEP_TYM: t_q <= ares[95:0];
        ngf_pkg::STEP_TXD, ngf_pkg::STEP_TYD: begin
          if (cmd_i.step == ngf_pkg::STEP_TXD) begin
            fx_q <= acc_out;
          end else begin
            fy_q <= acc_out;
          end
          if (term_clip || sum_ovf) begin
            sat_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.emit) begin
      res_q.particle_index <= cmd_i.out_idx;
      res_q.force_x        <= fx_q;
      res_q.force_y        <= fy_q;
      res_q.coincident     <= coin_q;
      res_q.saturated      <= sat_q;
      res_q.last_result    <= cmd_i.out_last;
    end
  end

  // Result strobe lasts one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
    end
  end

  assign status_o.done      = done;
  assign status_o.pair_zero = xz_q && yz_q;
  assign result_valid_o     = valid_q;
  assign result_o           = res_q;

endmodule

// File: src/ngf_ctrl.sv
// Controller: particle loading and sequencing of pair evaluations.
`include "assert_macros.svh"

module ngf_ctrl #(
  parameter int MaxParticles = ngf_pkg::MAX_PARTICLES_DEF,
  localparam int AddrW = $clog2(MaxParticles),
  localparam int CntW = $clog2(MaxParticles + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                last_i,
  input  ngf_pkg::dp_status_t status_i,
  output ngf_pkg::ctrl_cmd_t  cmd_o,
  output logic [AddrW-1:0]    rd_addr_o,
  output logic [AddrW-1:0]    wr_addr_o,
  output logic                busy
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_IRD  = 4'd1;
  localparam logic [3:0] S_ILAT = 4'd2;
  localparam logic [3:0] S_JCHK = 4'd3;
  localparam logic [3:0] S_JRD  = 4'd4;
  localparam logic [3:0] S_JTST = 4'd5;
  localparam logic [3:0] S_GO   = 4'd6;
  localparam logic [3:0] S_WAIT = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxParticles);

  logic [3:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d, n_q, n_d, i_q, i_d, j_q, j_d, cnt_inc;
  logic [3:0]      step_q, step_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    n_d     = n_q;
    i_d     = i_q;
    j_d     = j_q;
    step_d  = step_q;
    cnt_inc = count_q;
    cmd_o   = '0;
    cmd_o.step     = step_q;
    cmd_o.out_idx  = (ngf_pkg::IDX_W)'(i_q);
    cmd_o.out_last = (i_q == n_q - CntW'(1));
    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (count_q != MaxCnt) begin
            cmd_o.mem_we = 1'b1;
            cnt_inc = count_q + CntW'(1);
          end
          if (last_i) begin
            n_d     = cnt_inc;
            count_d = '0;
            i_d     = '0;
            state_d = S_IRD;
          end else begin
            count_d = cnt_inc;
          end
        end
      end
      S_IRD: state_d = S_ILAT;
      S_ILAT: begin
        cmd_o.latch_i = 1'b1;
        j_d = '0;
        state_d = S_JCHK;
      end
      S_JCHK: begin
        if (j_q == n_q) begin
          state_d = S_EMIT;
        end else if (j_q == i_q) begin
          j_d = j_q + CntW'(1);
        end else begin
          state_d = S_JRD;
        end
      end
      S_JRD: begin
        cmd_o.latch_d = 1'b1;
        state_d = S_JTST;
      end
      S_JTST: begin
        if (status_i.pair_zero) begin
          cmd_o.set_coin = 1'b1;
          j_d = j_q + CntW'(1);
          state_d = S_JCHK;
        end else begin
          step_d = ngf_pkg::STEP_UXX;
          state_d = S_GO;
        end
      end
      S_GO: begin
        cmd_o.go = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (status_i.done) begin
          if (step_q == ngf_pkg::STEP_TYD) begin
            j_d = j_q + CntW'(1);
            state_d = S_JCHK;
          end else begin
            step_d = step_q + 4'd1;
            state_d = S_GO;
          end
        end
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        if (i_q == n_q - CntW'(1)) begin
          state_d = S_IDLE;
        end else begin
          i_d = i_q + CntW'(1);
          state_d = S_IRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      n_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      step_q  <= ngf_pkg::STEP_UXX;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      n_q     <= n_d;
      i_q     <= i_d;
      j_q     <= j_d;
      step_q  <= step_d;
    end
  end

  assign rd_addr_o = (state_q == S_IRD) ? i_q[AddrW-1:0] : j_q[AddrW-1:0];
  assign wr_addr_o = count_q[AddrW-1:0];
  assign busy      = (state_q != S_IDLE);

  `ASSERT_IMP(a_emit_after_all_j, clk_i, rst_ni, state_q == S_EMIT, j_q == n_q)
  `ASSERT_IMP(a_i_in_set, clk_i, rst_ni, state_q != S_IDLE, i_q < n_q)
  `ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= MaxCnt)

endmodule

// File: src/nbody_gravity_force_2d.sv
// Load a particle set of up to MaxParticles, then emit one total 2D gravity force per item.
// A particle without the last marker is taken and gives no result.
// Each pair with distinct positions runs on the shared iterative unit
// (six 64-step multiplies, three 128-step divides, one 33-step square root); a
// coincident pair skips the unit. N results follow, never held off.
// Reset clears the set and loads the default gravity constant; the stores need no clearing.
module nbody_gravity_force_2d #(
  parameter int MaxParticles = ngf_pkg::MAX_PARTICLES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  ngf_pkg::in_item_t          item_i,
  input  logic                       cfg_we_i,
  input  logic [ngf_pkg::GRAV_W-1:0] cfg_wdata_i,
  output logic                       result_valid_o,
  output ngf_pkg::out_item_t         result_o
);

  localparam int AddrW = $clog2(MaxParticles);

  ngf_pkg::ctrl_cmd_t  cmd;
  ngf_pkg::dp_status_t status;
  logic [AddrW-1:0]    rd_addr, wr_addr;

  ngf_ctrl #(.MaxParticles(MaxParticles)) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .last_i    (item_i.last_particle),
    .status_i  (status),
    .cmd_o     (cmd),
    .rd_addr_o (rd_addr),
    .wr_addr_o (wr_addr),
    .busy      (busy)
  );

  ngf_dpath #(.MaxParticles(MaxParticles)) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .rd_addr_i      (rd_addr),
    .wr_addr_i      (wr_addr),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// File: dv/nbody_gravity_force_2d_tb.sv
// Self-checking testbench of the 2D gravity force block with a built-in force predictor.
`timescale 1ns / 1ps

module nbody_gravity_force_2d_tb;

  localparam int MaxSet = ngf_pkg::MAX_PARTICLES_DEF;

  // Predicts the forces of each particle set and checks the emitted results in order.
  class force_scoreboard;
    logic [ngf_pkg::GRAV_W-1:0] grav;
    longint                     px[MaxSet];
    longint                     py[MaxSet];
    logic [31:0]                pm[MaxSet];
    int                         loaded;
    ngf_pkg::out_item_t         pending[$];
    int                         mismatches;

    function new();
      grav = ngf_pkg::GRAV_RESET;
      loaded = 0;
      mismatches = 0;
    endfunction

    // Floor square root of a distance squared.
    function logic [63:0] isqrt(logic [127:0] v);
      logic [127:0] r;
      logic [127:0] c;
      r = '0;
      for (int b = 33; b >= 0; b--) begin
        c = r | (128'd1 << b);
        if (c * c <= v) r = c;
      end
      return r[63:0];
    endfunction

    // One component term: F*u/d, clipped, with the sign of the offset.
    function longint force_term(logic [63:0] f, logic [63:0] u, logic [63:0] d,
                                longint delta, inout bit sat);
      logic [127:0] t;
      logic [63:0]  m;
      if (delta == 0) return 0;
      t = ({64'd0, f} * {64'd0, u}) / {64'd0, d};
      if (t > 128'h7FFF_FFFF_FFFF_FFFF) begin
        sat = 1;
        m = 64'h7FFF_FFFF_FFFF_FFFF;
      end else begin
        m = t[63:0];
      end
      return (delta > 0) ? longint'(m) : -longint'(m);
    endfunction

    // Signed 64-bit add with clipping.
    function longint clip_add(longint a, longint b, inout bit sat);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
        sat = 1;
        return 64'sh7FFF_FFFF_FFFF_FFFF;
      end
      if (s < -65'sh0_8000_0000_0000_0000) begin
        sat = 1;
        return 64'sh8000_0000_0000_0000;
      end
      return longint'(s[63:0]);
    endfunction

    // Stores an accepted particle; a last marker queues the forces of the whole set.
    function void note_particle(ngf_pkg::in_item_t it);
      longint             dx, dy, fx, fy, tx, ty;
      logic [63:0]        ux, uy, d, f, mm;
      logic [127:0]       d2, num, q;
      bit                 coin, sat;
      ngf_pkg::out_item_t r;
      if (loaded < MaxSet) begin
        px[loaded] = longint'(it.pos_x);
        py[loaded] = longint'(it.pos_y);
        pm[loaded] = it.mass;
        loaded++;
      end
      if (!it.last_particle) return;
      for (int i = 0; i < loaded; i++) begin
        fx = 0;
        fy = 0;
        coin = 0;
        sat = 0;
        for (int j = 0; j < loaded; j++) begin
          if (j == i) continue;
          dx = px[j] - px[i];
          dy = py[j] - py[i];
          if (dx == 0 && dy == 0) begin
            coin = 1;
            continue;
          end
          ux = (dx < 0) ? -dx : dx;
          uy = (dy < 0) ? -dy : dy;
          d2 = {64'd0, ux} * {64'd0, ux} + {64'd0, uy} * {64'd0, uy};
          d = isqrt(d2);
          mm = {32'd0, pm[i]} * {32'd0, pm[j]};
          num = ({80'd0, grav} * {64'd0, mm}) << 16;
          q = num / d2;
          if (q[127:64] != 0) begin
            sat = 1;
            f = '1;
          end else begin
            f = q[63:0];
          end
          // Each term is formed before its add so that both clip flags are kept.
          tx = force_term(f, ux, d, dx, sat);
          fx = clip_add(fx, tx, sat);
          ty = force_term(f, uy, d, dy, sat);
          fy = clip_add(fy, ty, sat);
        end
        r.particle_index = i[ngf_pkg::IDX_W-1:0];
        r.force_x = fx;
        r.force_y = fy;
        r.coincident = coin;
        r.saturated = sat;
        r.last_result = (i + 1 == loaded);
        pending = {pending, r};
      end
      loaded = 0;
    endfunction

    // Compares one emitted force with the oldest prediction.
    function void check_force(ngf_pkg::out_item_t got);
      ngf_pkg::out_item_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got.particle_index !== exp_r.particle_index || got.force_x !== exp_r.force_x ||
          got.force_y !== exp_r.force_y || got.coincident !== exp_r.coincident ||
          got.saturated !== exp_r.saturated || got.last_result !== exp_r.last_result) begin
        mismatches++;
        if (mismatches <= 10) $display("Mismatch: expected %p, got %p", exp_r, got);
      end
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  ngf_pkg::in_item_t          item_i;
  logic                       cfg_we_i;
  logic [ngf_pkg::GRAV_W-1:0] cfg_wdata_i;
  logic                       result_valid_o;
  ngf_pkg::out_item_t         result_o;

  force_scoreboard   sb;
  int                idle_pct;

  nbody_gravity_force_2d u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Results are taken at the edge that ends their cycle.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_force(result_o);
  end

  // Offers one particle, waits for it to be taken, then idles at random.
  task automatic send_particle(logic [31:0] x, logic [31:0] y, logic [31:0] m, bit last);
    start <= 1'b1;
    item_i <= '{pos_x: x, pos_y: y, mass: m, last_particle: last};
    do @(posedge clk_i); while (busy);
    sb.note_particle('{pos_x: x, pos_y: y, mass: m, last_particle: last});
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Holds off until every predicted force has come and the block is idle.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_gravity(logic [ngf_pkg::GRAV_W-1:0] g);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= g;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.grav = g;
  endtask

  // Random coordinate: mostly near the origin, sometimes anywhere.
  function automatic logic [31:0] rand_pos();
    if ($urandom_range(3) == 0) return $urandom;
    return $urandom_range(32'h0010_0000) - 32'h0008_0000;
  endfunction

  // A random set of two to four particles, sometimes with a repeated position.
  task automatic random_set();
    int          n;
    logic [31:0] x, y, m;
    n = $urandom_range(4, 2);
    for (int k = 0; k < n; k++) begin
      if (k == 0 || $urandom_range(5) != 0) begin
        x = rand_pos();
        y = rand_pos();
      end
      m = ($urandom_range(1) == 0) ? $urandom : $urandom_range(1000);
      send_particle(x, y, m, k == n - 1);
    end
  endtask

  initial begin
    sb = new();
    idle_pct = 0;
    start = 1'b0;
    item_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single particle, extreme positions and masses, axis-aligned pairs.
    send_particle(32'h0001_0000, 32'h0002_0000, 32'd5, 1);
    send_particle(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 0);
    send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1);
    send_particle(32'h0000_0000, 32'h0000_0000, 32'd1000, 0);
    send_particle(32'h0000_0000, 32'h0001_0000, 32'd1000, 0);
    send_particle(32'h0001_0000, 32'h0000_0000, 32'd0, 1);
    send_particle(32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF, 0);
    send_particle(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1);
    // Coincident pair next to a third particle.
    send_particle(32'hFFFF_0000, 32'h0003_0000, 32'd7, 0);
    send_particle(32'hFFFF_0000, 32'h0003_0000, 32'd9, 0);
    send_particle(32'h0002_0000, 32'hFFFD_0000, 32'd11, 1);
    drain();

    // Extreme gravity settings.
    write_gravity('1);
    send_particle(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 0);
    send_particle(32'h0000_0100, 32'hFFFF_FF00, 32'hFFFF_FFFF, 0);
    send_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 1);
    write_gravity('0);
    send_particle(32'h0001_0000, 32'h0001_0000, 32'd100, 0);
    send_particle(32'h0002_0000, 32'h0003_0000, 32'd100, 1);
    write_gravity(ngf_pkg::GRAV_RESET);

    // Overflow: a full set at one position, then a dropped particle that carries the marker.
    idle_pct = 10;
    for (int k = 0; k <= MaxSet; k++)
      send_particle(32'h0004_0000, 32'hFFFC_0000, $urandom, k == MaxSet);

    // Random sets across idling phases and gravity settings.
    for (int s = 0; s < 16; s++) begin
      if (s % 4 == 0) begin
        idle_pct = (s / 4 == 0) ? 0 : (s / 4 == 1) ? 63 : (s / 4 == 2) ? 10 : 0;
        write_gravity((s / 4 == 3) ? 48'($urandom) << $urandom_range(16) :
                      48'({$urandom, $urandom}));
      end
      random_set();
    end
    drain();

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
